/* rtl/background_crop_square_analyzer_macros.svh */
// assertion macros shared by the analyzer modules
`ifndef BACKGROUND_CROP_SQUARE_ANALYZER_MACROS_SVH
`define BACKGROUND_CROP_SQUARE_ANALYZER_MACROS_SVH

`ifndef SYNTHESIS
// property checked on every rising edge of i_clk outside reset
`define BCSA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
// condition that must never hold outside reset
`define BCSA_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);
`else
`define BCSA_ASSERT(label, prop, msg)
`define BCSA_ASSERT_NEVER(label, cond, msg)
`endif

`endif

/* rtl/bcsa_pkg.sv */
// shared types, constants and helpers of the background crop square analyzer
package bcsa_pkg;

    localparam int MAX_SIDE = 4096;
    localparam int POS_W    = $clog2(MAX_SIDE);
    localparam int SIZE_W   = $clog2(MAX_SIDE + 1);
    localparam int CFG_W    = 13;
    localparam int MARGIN_W = 14;
    localparam int WIDE_W   = SIZE_W + 3;
    localparam int COLOR_W  = 8;
    localparam int DSUM_W   = COLOR_W + 2;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LARGE_THRESHOLD = 2'd2;

    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH     = 13'd64;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT    = 13'd64;
    localparam logic [CFG_W-1:0] RST_LARGE_THRESHOLD = 13'd80;

    localparam int IN_TDATA_W  = 3 * COLOR_W;
    localparam int OUT_TDATA_W = 4 * MARGIN_W + 3 * COLOR_W;
    localparam int OUT_TUSER_W = 2;

    typedef logic [COLOR_W-1:0]         t_color;
    typedef logic signed [WIDE_W-1:0]   t_wide;
    typedef logic signed [MARGIN_W-1:0] t_margin;

    typedef struct packed {
        t_color red;
        t_color green;
        t_color blue;
    } t_rgb;

    // bounding box snapshot taken on the last pixel of an image
    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  first_row;
        logic [POS_W-1:0]  last_row;
        logic [POS_W-1:0]  first_col;
        logic [POS_W-1:0]  last_col;
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic [CFG_W-1:0]  threshold;
        t_rgb              max_dist;
    } t_frame;

    typedef struct packed {
        t_margin top;
        t_margin bottom;
        t_margin left;
        t_margin right;
        t_rgb    max_dist;
        logic    not_empty;
        logic    needs_downscale;
    } t_result;

    // zero counts as one, anything past the maximum counts as the maximum
    function automatic logic [SIZE_W-1:0] eff_side(logic [CFG_W-1:0] v);
        if (v == '0) begin
            return SIZE_W'(1);
        end else if (v > CFG_W'(MAX_SIDE)) begin
            return SIZE_W'(MAX_SIDE);
        end
        return SIZE_W'(v);
    endfunction

    function automatic t_color absdiff(t_color a, t_color b);
        return (a > b) ? t_color'(a - b) : t_color'(b - a);
    endfunction

endpackage

/* rtl/bcsa_pixel.sv */
// per-pixel tracker: raster counters, reference color, farthest pixel and marked box
`include "background_crop_square_analyzer_macros.svh"

module bcsa_pixel (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  bcsa_pkg::t_rgb                i_pixel,
    input  logic [bcsa_pkg::CFG_W-1:0]    i_image_width,
    input  logic [bcsa_pkg::CFG_W-1:0]    i_image_height,
    input  logic [bcsa_pkg::CFG_W-1:0]    i_large_threshold,
    output logic                          o_frame_end,
    output bcsa_pkg::t_frame              o_frame
);

    logic [bcsa_pkg::SIZE_W-1:0] w;
    logic [bcsa_pkg::SIZE_W-1:0] h;

    logic [bcsa_pkg::POS_W-1:0]  r_col, n_col;
    logic [bcsa_pkg::POS_W-1:0]  r_row, n_row;
    bcsa_pkg::t_rgb              r_ref, n_ref;
    bcsa_pkg::t_rgb              r_max, n_max;
    logic [bcsa_pkg::DSUM_W-1:0] r_msum, n_msum;
    logic [bcsa_pkg::POS_W-1:0]  r_first_row, n_first_row;
    logic [bcsa_pkg::POS_W-1:0]  r_last_row, n_last_row;
    logic [bcsa_pkg::POS_W-1:0]  r_first_col, n_first_col;
    logic [bcsa_pkg::POS_W-1:0]  r_last_col, n_last_col;
    logic                        r_found, n_found;

    bcsa_pkg::t_rgb              ref_px;
    bcsa_pkg::t_rgb              px_dist;
    logic [bcsa_pkg::DSUM_W-1:0] dsum;
    logic [bcsa_pkg::SIZE_W:0]   col_inc;
    logic [bcsa_pkg::SIZE_W:0]   row_inc;
    logic                        col_end;
    logic                        row_end;

    assign w = bcsa_pkg::eff_side(i_image_width);
    assign h = bcsa_pkg::eff_side(i_image_height);

    assign col_inc = (bcsa_pkg::SIZE_W + 1)'(r_col) + 1'b1;
    assign row_inc = (bcsa_pkg::SIZE_W + 1)'(r_row) + 1'b1;
    assign col_end = col_inc >= {1'b0, w};
    assign row_end = row_inc >= {1'b0, h};
    assign o_frame_end = col_end && row_end;

    always_comb begin
        // the first pixel of an image is its own reference
        ref_px = (r_col == '0 && r_row == '0) ? i_pixel : r_ref;
        px_dist.red   = bcsa_pkg::absdiff(i_pixel.red, ref_px.red);
        px_dist.green = bcsa_pkg::absdiff(i_pixel.green, ref_px.green);
        px_dist.blue  = bcsa_pkg::absdiff(i_pixel.blue, ref_px.blue);
        dsum = bcsa_pkg::DSUM_W'(px_dist.red) + bcsa_pkg::DSUM_W'(px_dist.green)
             + bcsa_pkg::DSUM_W'(px_dist.blue);

        n_ref       = ref_px;
        n_max       = r_max;
        n_msum      = r_msum;
        n_first_row = r_first_row;
        n_last_row  = r_last_row;
        n_first_col = r_first_col;
        n_last_col  = r_last_col;
        n_found     = r_found;

        if (dsum > r_msum) begin
            n_max  = px_dist;
            n_msum = dsum;
        end
        if (dsum != '0) begin
            if (!r_found) begin
                n_first_row = r_row;
            end
            n_last_row = r_row;
            if (r_col < r_first_col) begin
                n_first_col = r_col;
            end
            if (r_col > r_last_col) begin
                n_last_col = r_col;
            end
            n_found = 1'b1;
        end

        n_col = col_end ? '0 : bcsa_pkg::POS_W'(col_inc);
        n_row = r_row;
        if (col_end) begin
            n_row = row_end ? '0 : bcsa_pkg::POS_W'(row_inc);
        end
    end

    always_comb begin
        o_frame.found     = n_found;
        o_frame.first_row = n_first_row;
        o_frame.last_row  = n_last_row;
        o_frame.first_col = n_first_col;
        o_frame.last_col  = n_last_col;
        o_frame.width     = w;
        o_frame.height    = h;
        o_frame.threshold = i_large_threshold;
        o_frame.max_dist  = n_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && o_frame_end)) begin
            r_col       <= '0;
            r_row       <= '0;
            r_ref       <= '0;
            r_max       <= '0;
            r_msum      <= '0;
            r_first_row <= '0;
            r_last_row  <= '0;
            r_first_col <= bcsa_pkg::POS_W'(bcsa_pkg::MAX_SIDE - 1);
            r_last_col  <= '0;
            r_found     <= 1'b0;
        end else if (i_accept) begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_ref       <= n_ref;
            r_max       <= n_max;
            r_msum      <= n_msum;
            r_first_row <= n_first_row;
            r_last_row  <= n_last_row;
            r_first_col <= n_first_col;
            r_last_col  <= n_last_col;
            r_found     <= n_found;
        end
    end

    `BCSA_ASSERT(a_box_ordered, r_found |-> (r_first_col <= r_last_col && r_first_row <= r_last_row), "marked box out of order")
    `BCSA_ASSERT(a_no_mark_no_dist, !r_found |-> (r_msum == '0 && r_max == '0), "distance kept without a marked pixel")
    `BCSA_ASSERT(a_restart, (i_accept && o_frame_end) |=> (r_col == '0 && r_row == '0 && !r_found), "tracker not cleared after last pixel")

endmodule

/* rtl/bcsa_square.sv */
// result pipeline: margins, squaring, clamping and the large-crop flag
`include "background_crop_square_analyzer_macros.svh"

module bcsa_square (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic              i_valid,
    input  bcsa_pkg::t_frame  i_frame,
    output logic              o_valid,
    output bcsa_pkg::t_result o_result
);

    typedef struct packed {
        bcsa_pkg::t_wide             top;
        bcsa_pkg::t_wide             bottom;
        bcsa_pkg::t_wide             left;
        bcsa_pkg::t_wide             right;
        bcsa_pkg::t_wide             box_h;
        bcsa_pkg::t_wide             box_w;
        logic                        found;
        logic [bcsa_pkg::SIZE_W-1:0] width;
        logic [bcsa_pkg::SIZE_W-1:0] height;
        logic [bcsa_pkg::CFG_W-1:0]  threshold;
        bcsa_pkg::t_rgb              max_dist;
    } t_box;

    logic              r_s1_valid;
    bcsa_pkg::t_frame  r_s1;
    logic              r_s2_valid;
    t_box              r_s2, n_s2;
    logic              r_s3_valid;
    t_box              r_s3, n_s3;
    logic              r_out_valid;
    bcsa_pkg::t_result r_result, n_result;

    bcsa_pkg::t_wide d;
    bcsa_pkg::t_wide nd;
    bcsa_pkg::t_wide cropped_w;
    logic [2*bcsa_pkg::WIDE_W-1:0] tb_pair;
    logic [2*bcsa_pkg::WIDE_W-1:0] lr_pair;

    // a negative side is handed to the opposite side, then the other way round
    function automatic logic [2*bcsa_pkg::WIDE_W-1:0] clamp_pair(bcsa_pkg::t_wide a,
                                                                 bcsa_pkg::t_wide b);
        bcsa_pkg::t_wide x;
        bcsa_pkg::t_wide y;
        x = a;
        y = b;
        if (x < 0) begin
            y = y + x;
            x = '0;
        end
        if (y < 0) begin
            x = x + y;
            y = '0;
        end
        return {x, y};
    endfunction

    // raw margins and box size
    always_comb begin
        n_s2.top       = bcsa_pkg::t_wide'(r_s1.first_row);
        n_s2.bottom    = bcsa_pkg::t_wide'(r_s1.height) - bcsa_pkg::t_wide'(r_s1.last_row)
                       - bcsa_pkg::t_wide'(1);
        n_s2.left      = bcsa_pkg::t_wide'(r_s1.first_col);
        n_s2.right     = bcsa_pkg::t_wide'(r_s1.width) - bcsa_pkg::t_wide'(r_s1.last_col)
                       - bcsa_pkg::t_wide'(1);
        n_s2.box_h     = bcsa_pkg::t_wide'(bcsa_pkg::POS_W'(r_s1.last_row - r_s1.first_row))
                       + bcsa_pkg::t_wide'(1);
        n_s2.box_w     = bcsa_pkg::t_wide'(bcsa_pkg::POS_W'(r_s1.last_col - r_s1.first_col))
                       + bcsa_pkg::t_wide'(1);
        n_s2.found     = r_s1.found;
        n_s2.width     = r_s1.width;
        n_s2.height    = r_s1.height;
        n_s2.threshold = r_s1.threshold;
        n_s2.max_dist  = r_s1.max_dist;
    end

    // grow the short side; only one pair moves, and when rows are added the
    // columns already match, so the column split always starts at left
    always_comb begin
        n_s3 = r_s2;
        d  = r_s2.box_w - r_s2.box_h;
        nd = r_s2.box_h - r_s2.box_w;
        if (d > 0) begin
            n_s3.top    = r_s2.top - ((d + bcsa_pkg::t_wide'(1)) >>> 1);
            n_s3.bottom = r_s2.bottom - (d >>> 1);
        end else begin
            n_s3.left   = r_s2.left - ((nd + bcsa_pkg::t_wide'(1)) >>> 1);
            n_s3.right  = r_s2.right - (nd >>> 1);
        end
    end

    always_comb begin
        tb_pair   = clamp_pair(r_s3.top, r_s3.bottom);
        lr_pair   = clamp_pair(r_s3.left, r_s3.right);
        // clamping keeps the pair sum, so the cropped width is known before it
        cropped_w = bcsa_pkg::t_wide'(r_s3.width) - (r_s3.left + r_s3.right);
        n_result.max_dist = r_s3.max_dist;
        if (r_s3.found) begin
            n_result.top             = bcsa_pkg::MARGIN_W'(tb_pair[2*bcsa_pkg::WIDE_W-1 -: bcsa_pkg::WIDE_W]);
            n_result.bottom          = bcsa_pkg::MARGIN_W'(tb_pair[bcsa_pkg::WIDE_W-1:0]);
            n_result.left            = bcsa_pkg::MARGIN_W'(lr_pair[2*bcsa_pkg::WIDE_W-1 -: bcsa_pkg::WIDE_W]);
            n_result.right           = bcsa_pkg::MARGIN_W'(lr_pair[bcsa_pkg::WIDE_W-1:0]);
            n_result.not_empty       = 1'b1;
            n_result.needs_downscale = cropped_w >= bcsa_pkg::t_wide'(r_s3.threshold);
        end else begin
            // empty image: whole height and width on every side
            n_result.top             = bcsa_pkg::MARGIN_W'(r_s3.height);
            n_result.bottom          = bcsa_pkg::MARGIN_W'(r_s3.height);
            n_result.left            = bcsa_pkg::MARGIN_W'(r_s3.width);
            n_result.right           = bcsa_pkg::MARGIN_W'(r_s3.width);
            n_result.not_empty       = 1'b0;
            n_result.needs_downscale = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_advance) begin
            r_s1_valid  <= i_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_s1     <= i_frame;
            r_s2     <= n_s2;
            r_s3     <= n_s3;
            r_result <= n_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

    `BCSA_ASSERT(a_empty_result, (r_out_valid && !r_result.not_empty) |-> (r_result.max_dist == '0 && !r_result.needs_downscale), "empty image with distance or downscale flag")
    `BCSA_ASSERT(a_pipe_moves, (r_s3_valid && i_advance) |=> r_out_valid, "result lost between last stage and output")
    `BCSA_ASSERT(a_hold_on_stall, (r_out_valid && !i_advance) |=> (r_out_valid && $stable(r_result)), "stalled result changed")

endmodule

/* rtl/background_crop_square_analyzer.sv */
// top level of the background crop square analyzer
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+-----------------------------------
//  pixel in  | in        | i_s_tvalid / o_s_tready   | i_s_tdata: red, green, blue
//  result    | out       | o_m_tvalid / i_m_tready   | o_m_tdata margins+dist, o_m_tuser
//  config    | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// one pixel per cycle while no result is stalled; the tracker updates on the transfer cycle itself
// the result of an image passes the s1, s2, s3 and result registers after its last pixel transfer
// a stalled result holds the whole result pipeline and the pixel input
// synchronous active-low reset restores sizes 64x64, threshold 80
// config writes are always accepted, as o_cfg_ready is tied high

module background_crop_square_analyzer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // red [7:0], green [15:8], blue [23:16]
    input  logic [bcsa_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // top_margin, bottom_margin, left_margin, right_margin (14 each),
    // max_dist_red, max_dist_green, max_dist_blue (8 each)
    output logic [bcsa_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // not_empty [0], needs_downscale [1]
    output logic [bcsa_pkg::OUT_TUSER_W-1:0]    o_m_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bcsa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bcsa_pkg::CFG_W-1:0]          i_cfg_data
);

    logic [bcsa_pkg::CFG_W-1:0] r_image_width;
    logic [bcsa_pkg::CFG_W-1:0] r_image_height;
    logic [bcsa_pkg::CFG_W-1:0] r_large_threshold;

    logic              advance;
    logic              accept;
    bcsa_pkg::t_rgb    pixel;
    logic              frame_end;
    bcsa_pkg::t_frame  frame;
    logic              res_valid;
    bcsa_pkg::t_result result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width     <= bcsa_pkg::RST_IMAGE_WIDTH;
            r_image_height    <= bcsa_pkg::RST_IMAGE_HEIGHT;
            r_large_threshold <= bcsa_pkg::RST_LARGE_THRESHOLD;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bcsa_pkg::CFG_IMAGE_WIDTH:     r_image_width     <= i_cfg_data;
                bcsa_pkg::CFG_IMAGE_HEIGHT:    r_image_height    <= i_cfg_data;
                bcsa_pkg::CFG_LARGE_THRESHOLD: r_large_threshold <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // the pipeline moves unless a finished result is waiting on the sink
    assign advance    = !(res_valid && !i_m_tready);
    assign o_s_tready = advance;
    assign accept     = i_s_tvalid && advance;

    assign pixel.red   = i_s_tdata[bcsa_pkg::COLOR_W-1:0];
    assign pixel.green = i_s_tdata[2*bcsa_pkg::COLOR_W-1:bcsa_pkg::COLOR_W];
    assign pixel.blue  = i_s_tdata[3*bcsa_pkg::COLOR_W-1:2*bcsa_pkg::COLOR_W];

    bcsa_pixel u_pixel (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_pixel           (pixel),
        .i_image_width     (r_image_width),
        .i_image_height    (r_image_height),
        .i_large_threshold (r_large_threshold),
        .o_frame_end       (frame_end),
        .o_frame           (frame)
    );

    bcsa_square u_square (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_valid   (accept && frame_end),
        .i_frame   (frame),
        .o_valid   (res_valid),
        .o_result  (result)
    );

    assign o_m_tvalid = res_valid;
    assign o_m_tdata  = {result.max_dist.blue, result.max_dist.green, result.max_dist.red,
                         result.right, result.left, result.bottom, result.top};
    assign o_m_tuser  = {result.needs_downscale, result.not_empty};

endmodule
